@@ src/linked_line_splice_manager_unit_macros.svh @@
// Assertion macros for the linked line splice manager.
`ifndef LINKED_LINE_SPLICE_MANAGER_UNIT_MACROS_SVH
`define LINKED_LINE_SPLICE_MANAGER_UNIT_MACROS_SVH
`define LLSM_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error(msg);
`define LLSM_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error(msg);
`endif

@@ src/llsm_pkg.sv @@
// Shared types and constants of the linked line splice manager.
package llsm_pkg;
	localparam int MembersDef = 256;
	localparam int LinesDef = 16;
	localparam int PtrW = 9;
	localparam logic [PtrW-1:0] PtrNone = 9'h1ff;
	localparam int KindW = 3;
	localparam logic [KindW-1:0] KindAppend = 3'd0;
	localparam logic [KindW-1:0] KindMove = 3'd1;
	localparam logic [KindW-1:0] KindRemove = 3'd2;
	localparam logic [KindW-1:0] KindRange = 3'd3;
	localparam logic [KindW-1:0] KindQuery = 3'd4;
	localparam logic [KindW-1:0] KindNop = 3'd5;
	localparam int CmdW = 40;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [3:0] line;
		logic [PtrW-1:0] q;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_APPEND_A, ST_APPEND_T, ST_RD1, ST_UNLINK, ST_RD2,
		ST_LINK_A, ST_LINK_B, ST_FIN, ST_OUT
	} state_t;
endpackage

@@ src/llsm_front.sv @@
// Front part: accepts commands, checks their ranges and queues them.
module llsm_front import llsm_pkg::*; #(
	parameter int MEMBERS = MembersDef,
	parameter int LINES = LinesDef
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cmd_t in_cmd,
	output logic q_valid,
	input logic q_ready,
	output cmd_t q_cmd
);
	cmd_t fifo_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t cls;
	logic ok;

	always_comb begin
		cls = in_cmd;
		case (in_cmd.kind)
			KindAppend: ok = 32'(in_cmd.a) < MEMBERS && 32'(in_cmd.line) < LINES;
			KindMove: ok = 32'(in_cmd.a) < MEMBERS && 32'(in_cmd.b) < MEMBERS;
			KindRemove: ok = 32'(in_cmd.a) < MEMBERS;
			KindRange: ok = 32'(in_cmd.a) < MEMBERS && 32'(in_cmd.b) < MEMBERS
				&& 32'(in_cmd.c) < MEMBERS;
			KindQuery: ok = 32'(in_cmd.q) < MEMBERS + LINES;
			default: ok = 1'b0;
		endcase
		if (!ok) cls.kind = KindNop;
	end

	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) fifo_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= !wr_q;
			if (q_valid && q_ready) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

@@ src/llsm_back.sv @@
// Back part: walks the pointer tables for one command and returns the result.
module llsm_back import llsm_pkg::*; #(
	parameter int MEMBERS = MembersDef,
	parameter int LINES = LinesDef
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input cmd_t q_cmd,
	output logic out_valid,
	input logic out_ready,
	output logic [PtrW-1:0] out_next,
	output logic [PtrW-1:0] out_prev
);
	localparam int Entries = MEMBERS + LINES;
	localparam int AW = $clog2(Entries);
	localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;

	logic [PtrW-1:0] nxt_mem [Entries];
	logic [PtrW-1:0] prv_mem [Entries];
	logic [PtrW-1:0] tail_q [LINES];

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [AW-1:0] clr_q;
	logic [PtrW-1:0] rd_n_q, rd_p_q;

	logic [PtrW-1:0] ea, eb, ec, tail_sel, lnk_u, lnk_v;
	logic is_range;
	logic wn, wp, rd_en, rt_en, tail_en;
	logic [PtrW-1:0] an, dn, ap, dp, ran, rap, rt_old;

	function automatic logic is_ent(logic [PtrW-1:0] e);
		return 32'(e) < Entries;
	endfunction

	function automatic logic [AW-1:0] ix(logic [PtrW-1:0] e);
		return AW'(e);
	endfunction

	assign ea = PtrW'(cmd_q.a);
	assign eb = PtrW'(cmd_q.b);
	assign ec = PtrW'(cmd_q.c);
	assign tail_sel = tail_q[LW'(cmd_q.line)];
	assign is_range = cmd_q.kind == KindRange;
	assign lnk_u = is_range ? eb : ea;
	assign lnk_v = is_range ? ec : eb;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == AW'(Entries - 1)) state_d = ST_IDLE;
			ST_IDLE: if (q_valid) begin
				case (q_cmd.kind)
					KindAppend: state_d = ST_APPEND_A;
					KindMove, KindRemove, KindRange: state_d = ST_RD1;
					KindQuery: state_d = ST_FIN;
					default: state_d = ST_OUT;
				endcase
			end
			ST_APPEND_A: state_d = ST_APPEND_T;
			ST_APPEND_T: state_d = ST_FIN;
			ST_RD1: state_d = ST_UNLINK;
			ST_UNLINK: state_d = (cmd_q.kind == KindRemove) ? ST_FIN : ST_RD2;
			ST_RD2: state_d = ST_LINK_A;
			ST_LINK_A: state_d = ST_LINK_B;
			ST_LINK_B: state_d = ST_FIN;
			ST_FIN: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// One read and one write per table in each cycle.
	always_comb begin
		wn = 1'b0; wp = 1'b0; rd_en = 1'b0; rt_en = 1'b0; tail_en = 1'b0;
		an = PtrNone; dn = PtrNone; ap = PtrNone; dp = PtrNone;
		ran = ea; rap = ea; rt_old = ea;
		case (state_q)
			ST_CLEAR: begin
				wn = 1'b1; an = PtrW'(clr_q);
				wp = 1'b1; ap = PtrW'(clr_q);
			end
			ST_APPEND_A: begin
				wn = 1'b1; an = ea;
				wp = 1'b1; ap = ea; dp = tail_sel;
			end
			ST_APPEND_T: begin
				wn = is_ent(tail_sel); an = tail_sel; dn = ea;
				tail_en = 1'b1;
			end
			ST_RD1: begin
				rd_en = 1'b1; ran = is_range ? eb : ea; rap = ea;
			end
			ST_UNLINK: begin
				wn = is_ent(rd_p_q); an = rd_p_q;
				dn = (is_range && !is_ent(rd_n_q)) ? PtrNone : rd_n_q;
				wp = is_ent(rd_n_q); ap = rd_n_q; dp = rd_p_q;
				rt_en = !is_range || !is_ent(rd_n_q);
				rt_old = is_range ? eb : ea;
			end
			ST_RD2: begin
				rd_en = 1'b1; rap = is_range ? ec : eb;
			end
			ST_LINK_A: begin
				wn = is_ent(rd_p_q); an = rd_p_q; dn = ea;
				wp = 1'b1; ap = ea; dp = rd_p_q;
			end
			ST_LINK_B: begin
				wn = 1'b1; an = lnk_u; dn = lnk_v;
				wp = 1'b1; ap = lnk_v; dp = lnk_u;
			end
			ST_FIN: begin
				rd_en = 1'b1;
				ran = (cmd_q.kind == KindQuery) ? cmd_q.q : ea;
				rap = ran;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wn) nxt_mem[ix(an)] <= dn;
		if (wp) prv_mem[ix(ap)] <= dp;
		if (rd_en) begin
			rd_n_q <= nxt_mem[ix(ran)];
			rd_p_q <= prv_mem[ix(rap)];
		end
		if (state_q == ST_IDLE && q_valid) cmd_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			for (int l = 0; l < LINES; l++) tail_q[l] <= PtrW'(MEMBERS + l);
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			for (int l = 0; l < LINES; l++)
				if (rt_en && tail_q[l] == rt_old) tail_q[l] <= rd_p_q;
			if (tail_en) tail_q[LW'(cmd_q.line)] <= ea;
		end
	end

	assign q_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;
	assign out_next = (cmd_q.kind == KindNop) ? PtrNone : rd_n_q;
	assign out_prev = (cmd_q.kind == KindNop) ? PtrNone : rd_p_q;
endmodule

@@ src/linked_line_splice_manager_unit.sv @@
// Top level of the linked line splice manager.
//  Channel | Dir | Payload
//  s_axis  | in  | kind, member_a, member_b, member_c, line_sel, query_entry
//  m_axis  | out | next_entry, prev_entry
// After reset the back part clears all MEMBERS + LINES (272 by default) table entries.
// Each command ends in ST_OUT; before it a query passes ST_FIN, an append ST_APPEND_A,
// ST_APPEND_T and ST_FIN, a remove ST_RD1, ST_UNLINK and ST_FIN, and a move or range move
// ST_RD1, ST_UNLINK, ST_RD2, ST_LINK_A, ST_LINK_B and ST_FIN. Two commands queue in front.
// Reset sets each tail to its line head. The result holds while m_axis_tready is low.
module linked_line_splice_manager_unit import llsm_pkg::*; #(
	parameter int MEMBERS = MembersDef,
	parameter int LINES = LinesDef
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// kind, member_a, member_b, member_c, line_sel, query_entry
	input logic [CmdW-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// next_entry, prev_entry, zero fill
	output logic [23:0] m_axis_tdata
);
	`include "linked_line_splice_manager_unit_macros.svh"

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;
	logic [PtrW-1:0] nx, pv;

	assign in_cmd.kind = s_axis_tdata[2:0];
	assign in_cmd.a = s_axis_tdata[10:3];
	assign in_cmd.b = s_axis_tdata[18:11];
	assign in_cmd.c = s_axis_tdata[26:19];
	assign in_cmd.line = s_axis_tdata[30:27];
	assign in_cmd.q = s_axis_tdata[39:31];

	llsm_front #(.MEMBERS(MEMBERS), .LINES(LINES)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd, .q_valid, .q_ready, .q_cmd
	);

	llsm_back #(.MEMBERS(MEMBERS), .LINES(LINES)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_next(nx), .out_prev(pv)
	);

	assign m_axis_tdata = {6'd0, pv, nx};

	`LLSM_ASSERT_IMP(a_take_idle, clk, arst_n, q_valid && q_ready, !m_axis_tvalid,
		"command taken while a result is pending")
	`LLSM_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
endmodule

@@ tb/linked_line_splice_manager_unit_checker.sv @@
// Checker that predicts linked line splice manager results and compares them.
`timescale 1ns / 1ps
module linked_line_splice_manager_unit_checker import llsm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [CmdW-1:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [23:0] m_axis_tdata,
	output int fail_count,
	output int pending_count,
	output int result_count
);
	localparam int Entries = MembersDef + LinesDef;

	logic [PtrW-1:0] next_ptr [Entries];
	logic [PtrW-1:0] prev_ptr [Entries];
	logic [PtrW-1:0] line_tail [LinesDef];
	logic [2*PtrW-1:0] expected_links [$];

	function automatic bit is_entry(logic [PtrW-1:0] e);
		return int'(e) < Entries;
	endfunction

	task automatic write_next(logic [PtrW-1:0] e, logic [PtrW-1:0] v);
		if (is_entry(e))
			next_ptr[e] = v;
	endtask

	task automatic write_prev(logic [PtrW-1:0] e, logic [PtrW-1:0] v);
		if (is_entry(e))
			prev_ptr[e] = v;
	endtask

	task automatic link_pair(logic [PtrW-1:0] p, logic [PtrW-1:0] q);
		write_next(p, q);
		write_prev(q, p);
	endtask

	task automatic move_tails(logic [PtrW-1:0] from, logic [PtrW-1:0] to);
		for (int l = 0; l < LinesDef; l++)
			if (line_tail[l] == from)
				line_tail[l] = to;
	endtask

	task automatic detach(logic [PtrW-1:0] x);
		logic [PtrW-1:0] p;
		logic [PtrW-1:0] n;
		p = prev_ptr[x];
		n = next_ptr[x];
		move_tails(x, p);
		write_next(p, n);
		write_prev(n, p);
	endtask

	task automatic apply_command(input logic [CmdW-1:0] raw);
		cmd_t cmd;
		logic [PtrW-1:0] a, b, c, pa, nb, rn, rp;
		bit applied;
		cmd = cmd_t'({raw[2:0], raw[10:3], raw[18:11], raw[26:19], raw[30:27], raw[39:31]});
		a = {1'b0, cmd.a};
		b = {1'b0, cmd.b};
		c = {1'b0, cmd.c};
		rn = PtrNone;
		rp = PtrNone;
		applied = 1'b0;
		case (cmd.kind)
			KindAppend: begin
				next_ptr[a] = PtrNone;
				link_pair(line_tail[cmd.line], a);
				line_tail[cmd.line] = a;
				applied = 1'b1;
			end
			KindMove: begin
				detach(a);
				link_pair(prev_ptr[b], a);
				link_pair(a, b);
				applied = 1'b1;
			end
			KindRemove: begin
				detach(a);
				applied = 1'b1;
			end
			KindRange: begin
				pa = prev_ptr[a];
				nb = next_ptr[b];
				if (is_entry(nb)) begin
					link_pair(pa, nb);
				end else begin
					write_next(pa, PtrNone);
					move_tails(b, pa);
				end
				link_pair(prev_ptr[c], a);
				link_pair(b, c);
				applied = 1'b1;
			end
			KindQuery: begin
				if (is_entry(cmd.q)) begin
					rn = next_ptr[cmd.q];
					rp = prev_ptr[cmd.q];
				end
			end
			default: ;
		endcase
		if (applied) begin
			rn = next_ptr[a];
			rp = prev_ptr[a];
		end
		expected_links.push_back({rp, rn});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Entries; i++) begin
				next_ptr[i] = PtrNone;
				prev_ptr[i] = PtrNone;
			end
			for (int l = 0; l < LinesDef; l++)
				line_tail[l] = PtrW'(MembersDef + l);
			expected_links.delete();
			fail_count <= 0;
			result_count <= 0;
			pending_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_count <= result_count + 1;
				if (expected_links.size() == 0) begin
					$error("result beat with nothing expected: %h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					logic [2*PtrW-1:0] exp_links;
					exp_links = expected_links.pop_front();
					if (m_axis_tdata[8:0] !== exp_links[8:0]) begin
						$error("next_entry expected %0d actual %0d",
							exp_links[8:0], m_axis_tdata[8:0]);
						fail_count <= fail_count + 1;
					end else if (m_axis_tdata[17:9] !== exp_links[17:9]) begin
						$error("prev_entry expected %0d actual %0d",
							exp_links[17:9], m_axis_tdata[17:9]);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_command(s_axis_tdata);
			pending_count <= expected_links.size();
		end
	end
endmodule

@@ tb/tb_linked_line_splice_manager_unit.sv @@
// Testbench top that drives command beats into the linked line splice manager.
`timescale 1ns / 1ps
module tb_linked_line_splice_manager_unit;
	import llsm_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [CmdW-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;
	int fail_count;
	int pending_count;
	int result_count;
	int sent_count;
	bit stall_mode;

	linked_line_splice_manager_unit dut (.*);

	linked_line_splice_manager_unit_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb_linked_line_splice_manager_unit: FAIL");
		$finish;
	end

	function automatic logic [CmdW-1:0] pack_command(logic [2:0] kind, logic [7:0] a,
			logic [7:0] b, logic [7:0] c, logic [3:0] line, logic [8:0] q);
		return {q, line, c, b, a, kind};
	endfunction

	task automatic send_beat(logic [CmdW-1:0] data);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic pause_sender();
		s_axis_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6))
			@(posedge clk);
	endtask

	function automatic logic [7:0] any_member();
		return 8'($urandom_range(0, 31) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 47));
	endfunction

	function automatic logic [CmdW-1:0] random_command();
		int pick;
		logic [2:0] kind;
		logic [8:0] q;
		pick = $urandom_range(0, 99);
		if (pick < 15) kind = KindAppend;
		else if (pick < 35) kind = KindMove;
		else if (pick < 45) kind = KindRemove;
		else if (pick < 65) kind = KindRange;
		else if (pick < 97) kind = KindQuery;
		else kind = 3'($urandom_range(KindNop, 7));
		q = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(256, 511))
			: 9'($urandom_range(0, 47));
		return pack_command(kind, any_member(), any_member(), any_member(),
			4'($urandom), q);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_mode <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_mode <= ~stall_mode;
			m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		sent_count = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int m = 0; m < 48; m++)
			send_beat(pack_command(KindAppend, 8'(m), 8'd0, 8'd0, 4'(m % 4), 9'd0));
		send_beat(pack_command(KindAppend, 8'd255, 8'd0, 8'd0, 4'd15, 9'd0));
		send_beat(pack_command(KindQuery, 8'd0, 8'd0, 8'd0, 4'd0, 9'd256));
		send_beat(pack_command(KindQuery, 8'd0, 8'd0, 8'd0, 4'd0, 9'd271));
		send_beat(pack_command(KindQuery, 8'd0, 8'd0, 8'd0, 4'd0, 9'd272));
		send_beat(pack_command(KindQuery, 8'd0, 8'd0, 8'd0, 4'd0, 9'd511));
		send_beat(pack_command(KindMove, 8'd4, 8'd0, 8'd0, 4'd0, 9'd0));
		send_beat(pack_command(KindMove, 8'd5, 8'd5, 8'd0, 4'd0, 9'd0));
		send_beat(pack_command(KindRemove, 8'd44, 8'd0, 8'd0, 4'd0, 9'd0));
		send_beat(pack_command(KindRemove, 8'd200, 8'd0, 8'd0, 4'd0, 9'd0));
		send_beat(pack_command(KindRange, 8'd9, 8'd17, 8'd2, 4'd0, 9'd0));
		send_beat(pack_command(KindRange, 8'd11, 8'd47, 8'd6, 4'd0, 9'd0));
		send_beat(pack_command(KindNop, 8'd1, 8'd2, 8'd3, 4'd4, 9'd5));
		send_beat(pack_command(3'd7, 8'hff, 8'hff, 8'hff, 4'hf, 9'h1ff));
		while (sent_count < 1760) begin
			repeat ($urandom_range(1, 40))
				send_beat(random_command());
			if ($urandom_range(0, 2) != 0)
				pause_sender();
		end
		s_axis_tvalid <= 1'b0;
		wait_cycles = 0;
		while (pending_count != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20)
			@(posedge clk);
		$display("Sent %0d command beats covering all kinds; checked %0d result beats.",
			sent_count, result_count);
		if (fail_count == 0 && pending_count == 0)
			$display("tb_linked_line_splice_manager_unit: PASS");
		else
			$display("tb_linked_line_splice_manager_unit: FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/llsm_pkg.sv
src/llsm_front.sv
src/llsm_back.sv
src/linked_line_splice_manager_unit.sv
tb/linked_line_splice_manager_unit_checker.sv
tb/tb_linked_line_splice_manager_unit.sv
